### hdl/tta_pkg.sv
package tta_pkg;

    // event codes
    localparam logic [2:0] REQ_START      = 3'd0;
    localparam logic [2:0] REQ_CMP_B      = 3'd1;
    localparam logic [2:0] REQ_CMP_A      = 3'd2;
    localparam logic [2:0] REQ_TL_BEGIN   = 3'd3;
    localparam logic [2:0] REQ_TL_END     = 3'd4;
    localparam logic [2:0] REQ_ONE_SHOT   = 3'd5;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam logic [15:0] PERIOD_RESET   = 16'd328;
    localparam logic [31:0] LATENCY_COUNTS = 32'd3;
    localparam logic [31:0] MIN_DELTA      = 32'd1;

    // request to the shared arithmetic unit
    typedef struct packed {
        logic start;
        logic mul;
    } alu_op_t;

endpackage

### hdl/tta_shared_alu.sv
module tta_shared_alu (
    input  logic               aclk,
    input  logic               aresetn,
    input  tta_pkg::alu_op_t   op,
    input  logic [31:0]        operand,
    input  logic [15:0]        period,
    output logic               done,
    output logic [31:0]        result,
    output logic [15:0]        remainder
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        mul_reg, mul_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] src_reg, src_next;
    logic [15:0] rem_reg, rem_next;

    logic [16:0] rem_shift;
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic        add_cin;
    logic [32:0] add_sum;

    // one shared adder: trial subtract for division, shift-add for multiply
    always_comb begin
        rem_shift = {rem_reg, src_reg[31]};
        if (mul_reg) begin
            add_a   = {acc_reg[30:0], 1'b0};
            add_b   = src_reg[31] ? {16'd0, period} : 32'd0;
            add_cin = 1'b0;
        end else begin
            add_a   = {15'd0, rem_shift};
            add_b   = ~{16'd0, period};
            add_cin = 1'b1;
        end
        add_sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
    end

    // sequencer for one divide (32 steps) or one multiply (16 steps)
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mul_next  = mul_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        src_next  = src_reg;
        rem_next  = rem_reg;
        if (op.start) begin
            busy_next = 1'b1;
            mul_next  = op.mul;
            cnt_next  = op.mul ? 5'd15 : 5'd31;
            acc_next  = 32'd0;
            rem_next  = 16'd0;
            src_next  = op.mul ? {operand[15:0], 16'd0} : operand;
        end else if (busy_reg) begin
            src_next = {src_reg[30:0], 1'b0};
            if (mul_reg) begin
                acc_next = add_sum[31:0];
            end else begin
                acc_next = {acc_reg[30:0], add_sum[32]};
                rem_next = add_sum[32] ? add_sum[15:0] : rem_shift[15:0];
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        mul_reg <= mul_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        src_reg <= src_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign result    = acc_reg;
    assign remainder = rem_reg;

endmodule

### hdl/tickless_tick_accountant_unit.sv
// Tick accountant for a tickless kernel timer.
// Input channel (s_*): one timer event per transfer with the free-running
// counter value; the block gives exactly one result transfer on m_* per event.
// Config: cfg_wr_en/cfg_wr_data write tick_period. The user must write it
// only while the block is idle; the block itself does not enforce this.
// A period of zero counts as one. Events that credit ticks run a 32-step
// restoring divide on the shared adder; tickless begin runs a 16-step
// shift-add multiply; start, one-shot, and events with no work skip the
// shared unit. One event is in flight at a time: a new event is taken only
// once the current one has finished.
// The output register lets a new event be taken while a result still waits;
// if the receiver stalls, the next event finishes and then holds until the
// output register is free.
// Reset: anchor 0, stretch closed, tick_period 328, no result pending.
module tickless_tick_accountant_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [31:0] s_counter_now,
    input  logic [31:0] s_counter_first,
    input  logic [15:0] s_ticks_ahead,
    input  logic [15:0] s_target_tick,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_ticks_credited,
    output logic        m_arm_compare_b,
    output logic        m_arm_compare_a,
    output logic [31:0] m_compare_delta,
    output logic        m_stretch_open
);

    logic [1:0]  state_reg, state_next;
    logic [15:0] period_reg;
    logic [31:0] anchor_reg, anchor_next;
    logic        stretched_reg, stretched_next;
    logic [2:0]  req_reg;
    logic [31:0] now_reg;
    logic [31:0] diff_reg;
    logic [15:0] base_reg;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_credit_reg, credit_calc;
    logic        out_arm_b_reg, arm_b_calc;
    logic        out_arm_a_reg, arm_a_calc;
    logic [31:0] out_delta_reg, delta_calc;
    logic        out_stretch_reg;

    logic [15:0] period_eff;
    logic        accept;
    logic        need_div;
    logic        need_mul;
    logic        fin_go;
    logic [31:0] diff_in;
    logic [15:0] base_in;
    tta_pkg::alu_op_t alu_op;
    logic        alu_done;
    logic [31:0] alu_result;
    logic [15:0] alu_rem;

    assign period_eff = (period_reg == 16'd0) ? 16'd1 : period_reg;
    assign s_ready    = (state_reg == tta_pkg::ST_IDLE);
    assign accept     = s_valid && s_ready;

    // which events need the shared unit
    always_comb begin
        need_div = 1'b0;
        need_mul = 1'b0;
        unique case (s_req_type)
            tta_pkg::REQ_CMP_B:    need_div = 1'b1;
            tta_pkg::REQ_CMP_A:    need_div = stretched_reg;
            tta_pkg::REQ_TL_END:   need_div = stretched_reg;
            tta_pkg::REQ_TL_BEGIN: need_mul = 1'b1;
            default: begin
            end
        endcase
    end

    // distance from the anchor, or latency-adjusted distance for one-shot; one-shot target base of at least one
    always_comb begin
        if (s_req_type == tta_pkg::REQ_ONE_SHOT) begin
            diff_in = s_counter_now - s_counter_first + tta_pkg::LATENCY_COUNTS;
        end else begin
            diff_in = s_counter_now - anchor_reg;
        end
        base_in = s_target_tick - s_counter_first[15:0];
        if (base_in == 16'd0) begin
            base_in = 16'd1;
        end
    end

    // kick the shared unit on a transfer that needs it
    always_comb begin
        alu_op.start = accept && (need_div || need_mul);
        alu_op.mul   = need_mul;
    end

    tta_shared_alu u_alu (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (alu_op),
        .operand   (need_mul ? {16'd0, s_ticks_ahead} : diff_in),
        .period    (period_eff),
        .done      (alu_done),
        .result    (alu_result),
        .remainder (alu_rem)
    );

    assign fin_go = (state_reg == tta_pkg::ST_FIN) && (!out_valid_reg || m_ready);

    // result fields and state update of the finishing event
    always_comb begin
        credit_calc    = 32'd0;
        arm_b_calc     = 1'b0;
        arm_a_calc     = 1'b0;
        delta_calc     = 32'd0;
        anchor_next    = anchor_reg;
        stretched_next = stretched_reg;
        unique case (req_reg)
            tta_pkg::REQ_START: begin
                anchor_next    = now_reg;
                stretched_next = 1'b0;
                delta_calc     = {16'd0, period_eff};
                arm_b_calc     = 1'b1;
            end
            tta_pkg::REQ_CMP_B: begin
                credit_calc    = alu_result;
                anchor_next    = now_reg - {16'd0, alu_rem};
                stretched_next = 1'b0;
                delta_calc     = {16'd0, period_eff - alu_rem};
                arm_b_calc     = 1'b1;
            end
            tta_pkg::REQ_CMP_A: begin
                if (stretched_reg) begin
                    credit_calc = alu_result;
                    anchor_next = now_reg - {16'd0, alu_rem};
                end
            end
            tta_pkg::REQ_TL_BEGIN: begin
                delta_calc     = (alu_result > diff_reg) ? (alu_result - diff_reg)
                                                         : tta_pkg::MIN_DELTA;
                stretched_next = 1'b1;
                arm_b_calc     = 1'b1;
            end
            tta_pkg::REQ_TL_END: begin
                if (stretched_reg) begin
                    credit_calc    = alu_result;
                    anchor_next    = now_reg - {16'd0, alu_rem};
                    stretched_next = 1'b0;
                    delta_calc     = {16'd0, period_eff - alu_rem};
                    arm_b_calc     = 1'b1;
                end
            end
            tta_pkg::REQ_ONE_SHOT: begin
                delta_calc = ({16'd0, base_reg} > diff_reg)
                             ? ({16'd0, base_reg} - diff_reg) : tta_pkg::MIN_DELTA;
                arm_a_calc = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tta_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (need_div || need_mul) ? tta_pkg::ST_CALC
                                                        : tta_pkg::ST_FIN;
                end
            end
            tta_pkg::ST_CALC: begin
                if (alu_done) begin
                    state_next = tta_pkg::ST_FIN;
                end
            end
            tta_pkg::ST_FIN: begin
                if (fin_go) begin
                    state_next = tta_pkg::ST_IDLE;
                end
            end
            default: state_next = tta_pkg::ST_IDLE;
        endcase
    end

    // output register handshake
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (fin_go) begin
            out_valid_next = 1'b1;
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tta_pkg::ST_IDLE;
            period_reg    <= tta_pkg::PERIOD_RESET;
            anchor_reg    <= 32'd0;
            stretched_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                period_reg <= cfg_wr_data;
            end
            if (fin_go) begin
                anchor_reg    <= anchor_next;
                stretched_reg <= stretched_next;
            end
        end
    end

    // event capture and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg  <= s_req_type;
            now_reg  <= s_counter_now;
            diff_reg <= diff_in;
            base_reg <= base_in;
        end
        if (fin_go) begin
            out_credit_reg  <= credit_calc;
            out_arm_b_reg   <= arm_b_calc;
            out_arm_a_reg   <= arm_a_calc;
            out_delta_reg   <= delta_calc;
            out_stretch_reg <= stretched_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_ticks_credited = out_credit_reg;
    assign m_arm_compare_b  = out_arm_b_reg;
    assign m_arm_compare_a  = out_arm_a_reg;
    assign m_compare_delta  = out_delta_reg;
    assign m_stretch_open   = out_stretch_reg;

endmodule
